>>> rtl/sas_pkg.sv
// ---------------------------------------------------------------------------
// sas_pkg: shared types and constants of the softmax action selector
// Entry layout of the sorting chain, chain control, result status codes and
// the fixed-point constants of the weight datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

    localparam int MAX_ACTIONS = 16;
    localparam int IDX_W       = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_ACTIONS + 1);
    localparam int SUM_W       = 32 + IDX_W;

    localparam logic [14:0] LOG10E_Q16 = 15'd28462;
    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;

    // status codes of a result
    localparam logic [1:0] ST_SOFTMAX  = 2'd0;
    localparam logic [1:0] ST_UNIFORM  = 2'd1;
    localparam logic [1:0] ST_POSITIVE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [15:0]      id;
        logic [31:0]      weight;
        logic [IDX_W-1:0] idx;
    } cell_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        rem  = x;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > rem) begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.30 (Q2.30 word), built by repeated floor square roots
    function automatic logic [31:0] pow_root(input int k);
        logic [63:0] root;
        root = 64'd1 << 31;
        for (int j = 1; j <= 16; j++) begin
            if (j <= k) begin
                root = isqrt64(root << 30);
            end
        end
        return root[31:0];
    endfunction

    localparam logic [31:0] ROOT_TBL [16] = '{
        pow_root(1),  pow_root(2),  pow_root(3),  pow_root(4),
        pow_root(5),  pow_root(6),  pow_root(7),  pow_root(8),
        pow_root(9),  pow_root(10), pow_root(11), pow_root(12),
        pow_root(13), pow_root(14), pow_root(15), pow_root(16)
    };

endpackage

`default_nettype wire

>>> rtl/sas_weight_unit.sv
// ---------------------------------------------------------------------------
// sas_weight_unit: iterative weight computation
// weight = 2^(-log10(e)*log2(-value)/tau), value Q16.16, tau Q8.8, weight
// Q16.16, saturated. Log by sixteen squarings, restoring divide one bit per
// cycle, power by sixteen root multiplications.
// ---------------------------------------------------------------------------
`default_nettype none

module sas_weight_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] value,
    input  wire logic [15:0] tau,
    output logic             busy,
    output logic             done,
    output logic [31:0]      weight
);
    import sas_pkg::*;

    typedef enum logic [6:0] {
        W_IDLE = 7'b0000001,
        W_LOG  = 7'b0000010,
        W_MUL  = 7'b0000100,
        W_DIV  = 7'b0001000,
        W_EXP  = 7'b0010000,
        W_POW  = 7'b0100000,
        W_FIN  = 7'b1000000
    } wstate_t;

    localparam int DIV_BITS = 28;

    wstate_t     state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] y_reg, y_next;
    logic [4:0]  p_reg, p_next;
    logic [15:0] frac_reg, frac_next;
    logic        neg_reg, neg_next;
    logic [27:0] div_reg, div_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] prod_reg, prod_next;
    logic [4:0]  n_reg, n_next;
    logic [31:0] weight_reg, weight_next;
    logic        done_reg, done_next;

    logic [31:0] m;
    logic [4:0]  lead;
    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [21:0] lx;
    logic [20:0] lxa;
    logic [35:0] mag;
    logic [15:0] tau_eff;
    logic [16:0] trial;
    logic [20:0] ep;
    logic [63:0] pmul;
    logic [63:0] wide;

    always_comb begin
        m    = 32'(-value);
        lead = '0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) begin
                lead = 5'(i);
            end
        end
    end

    assign sq      = y_reg * y_reg;
    assign sq_sh   = sq[63:31];
    assign lx      = {1'b0, p_reg, frac_reg} - 22'h10_0000;
    assign lxa     = lx[21] ? 21'(-lx) : lx[20:0];
    assign mag     = lxa * LOG10E_Q16;
    assign tau_eff = (tau == 16'd0) ? 16'd1 : tau;
    assign trial   = {rem_reg, div_reg[DIV_BITS-1]};
    assign ep      = neg_reg ? (21'h10_0000 - div_reg[20:0]) : (21'h10_0000 + div_reg[20:0]);
    assign pmul    = prod_reg * ROOT_TBL[step_reg[3:0]];
    assign wide    = {32'd0, prod_reg} << n_reg;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        frac_next   = frac_reg;
        neg_next    = neg_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        prod_next   = prod_reg;
        n_next      = n_reg;
        weight_next = weight_reg;
        done_next   = 1'b0;
        case (state_reg)
            W_IDLE: begin
                if (start) begin
                    y_next     = m << (5'd31 - lead);
                    p_next     = lead;
                    frac_next  = '0;
                    step_next  = '0;
                    state_next = W_LOG;
                end
            end
            W_LOG: begin
                if (sq_sh[32]) begin
                    y_next    = sq_sh[32:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end else begin
                    y_next    = sq_sh[31:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd15) begin
                    state_next = W_MUL;
                end
            end
            W_MUL: begin
                // positive log gives a negative exponent
                neg_next   = !lx[21] && (lx != '0);
                div_next   = mag[35:8];
                rem_next   = '0;
                step_next  = '0;
                state_next = W_DIV;
            end
            W_DIV: begin
                if (trial >= {1'b0, tau_eff}) begin
                    rem_next = 16'(trial - {1'b0, tau_eff});
                    div_next = {div_reg[DIV_BITS-2:0], 1'b1};
                end else begin
                    rem_next = trial[15:0];
                    div_next = {div_reg[DIV_BITS-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(DIV_BITS - 1)) begin
                    state_next = W_EXP;
                end
            end
            W_EXP: begin
                if (!neg_reg && div_reg >= 28'h10_0000) begin
                    weight_next = '1;
                    done_next   = 1'b1;
                    state_next  = W_IDLE;
                end else if (neg_reg && div_reg > 28'h10_0000) begin
                    weight_next = '0;
                    done_next   = 1'b1;
                    state_next  = W_IDLE;
                end else begin
                    n_next     = ep[20:16];
                    frac_next  = ep[15:0];
                    prod_next  = 32'h4000_0000;
                    step_next  = '0;
                    state_next = W_POW;
                end
            end
            W_POW: begin
                if (frac_reg[15]) begin
                    prod_next = pmul[61:30];
                end
                frac_next = {frac_reg[14:0], 1'b0};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd15) begin
                    state_next = W_FIN;
                end
            end
            W_FIN: begin
                weight_next = wide[61:30];
                done_next   = 1'b1;
                state_next  = W_IDLE;
            end
            default: begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        step_reg   <= step_next;
        y_reg      <= y_next;
        p_reg      <= p_next;
        frac_reg   <= frac_next;
        neg_reg    <= neg_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        prod_reg   <= prod_next;
        n_reg      <= n_next;
        weight_reg <= weight_next;
    end

    assign busy   = (state_reg != W_IDLE);
    assign done   = done_reg;
    assign weight = weight_reg;

endmodule

`default_nettype wire

>>> rtl/sas_cell.sv
// ---------------------------------------------------------------------------
// sas_cell: one slot of the insertion sorting chain
// Holds one entry; on insert takes the new entry or its upper neighbor,
// on shift takes its lower neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module sas_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sas_pkg::cell_ctrl_t ctrl,
    input  wire sas_pkg::cell_t      new_entry,
    input  wire sas_pkg::cell_t      prev_entry,
    input  wire logic                prev_gt,
    input  wire sas_pkg::cell_t      next_entry,
    output sas_pkg::cell_t           entry,
    output logic                     gt
);
    import sas_pkg::*;

    cell_t entry_reg, entry_next;

    // strictly greater keeps equal weights in load order
    assign gt = !entry_reg.valid || (new_entry.weight > entry_reg.weight);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.clear) begin
            entry_next.valid = 1'b0;
        end else if (ctrl.shift) begin
            entry_next = next_entry;
        end else if (ctrl.insert && gt) begin
            entry_next = prev_gt ? prev_entry : new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

>>> rtl/softmax_action_selector_unit.sv
// Flow: a request is taken in idle, a negative value then runs through the
//   iterative weight unit (zero and positive values skip it), and the entry
//   is inserted; a last request then adds a threshold step, a walk over up to
//   MAX_ACTIONS entries and an output step.
// A new request is taken only once the previous one has been inserted, as
//   s_ready is high only in the idle state.
// Reset: synchronous active-low aresetn empties the chain and loads tau = 256.
// ---------------------------------------------------------------------------
// softmax_action_selector_unit: Boltzmann roulette-wheel action selector
// Loads (id, value) requests into a descending insertion chain, walks it from the
// head accumulating weights against random * total, or load index vs rnd*count.
// ---------------------------------------------------------------------------
`default_nettype none

module softmax_action_selector_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // temperature write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_temperature,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_action_id,
    input  wire logic signed [31:0] s_action_value,
    input  wire logic [15:0] s_random_fraction,
    input  wire logic        s_last_item,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_chosen_action,
    output logic [1:0]       m_status
);
    import sas_pkg::*;

    typedef enum logic [5:0] {
        T_IDLE = 6'b000001,
        T_CALC = 6'b000010,
        T_INS  = 6'b000100,
        T_THR  = 6'b001000,
        T_WALK = 6'b010000,
        T_OUT  = 6'b100000
    } tstate_t;

    tstate_t          state_reg, state_next;
    logic [15:0]      tau_reg, tau_next;
    logic [15:0]      id_reg, id_next;
    logic [31:0]      value_reg, value_next;
    logic [15:0]      rnd_reg, rnd_next;
    logic             last_reg, last_next;
    logic [31:0]      w_reg, w_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             zero_reg, zero_next;
    logic [1:0]       err_reg, err_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic [SUM_W-1:0] thresh_reg, thresh_next;
    logic [CNT_W-1:0] target_reg, target_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [15:0]      chosen_reg, chosen_next;
    logic             m_valid_reg, m_valid_next;
    logic [15:0]      m_chosen_reg, m_chosen_next;
    logic [1:0]       m_status_reg, m_status_next;

    logic             unit_start;
    logic             unit_busy;
    logic             unit_done;
    logic [31:0]      unit_weight;
    cell_ctrl_t       chain_ctrl;
    cell_t            new_entry;
    cell_t            cells [MAX_ACTIONS];
    logic             gts [MAX_ACTIONS];
    logic [SUM_W-1:0] total_sel;
    logic [SUM_W+15:0] thr_prod;
    logic [CNT_W+15:0] tgt_prod;
    logic [SUM_W-1:0] sum_add;
    logic             hit;
    logic             accept;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;

    sas_weight_unit u_weight (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .value   (value_reg),
        .tau     (tau_reg),
        .busy    (unit_busy),
        .done    (unit_done),
        .weight  (unit_weight)
    );

    assign new_entry.valid  = 1'b1;
    assign new_entry.id     = id_reg;
    assign new_entry.weight = w_reg;
    assign new_entry.idx    = count_reg[IDX_W-1:0];

    // insertion chain: cell 0 is the head, holding the largest weight
    for (genvar g = 0; g < MAX_ACTIONS; g++) begin : g_chain
        cell_t prev_c;
        cell_t next_c;
        logic  prev_g;
        if (g == 0) begin : g_head
            assign prev_c = '0;
            assign prev_g = 1'b0;
        end else begin : g_body
            assign prev_c = cells[g-1];
            assign prev_g = gts[g-1];
        end
        if (g == MAX_ACTIONS - 1) begin : g_tail
            assign next_c = '0;
        end else begin : g_mid
            assign next_c = cells[g+1];
        end
        sas_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (chain_ctrl),
            .new_entry  (new_entry),
            .prev_entry (prev_c),
            .prev_gt    (prev_g),
            .next_entry (next_c),
            .entry      (cells[g]),
            .gt         (gts[g])
        );
    end

    // uniform case: total is count * 1.0, and the pick is load index rnd*count
    assign total_sel = zero_reg ? (SUM_W'(count_reg) << 16) : total_reg;
    assign thr_prod  = rnd_reg * total_sel;
    assign tgt_prod  = rnd_reg * count_reg;
    assign sum_add   = sum_reg + SUM_W'(cells[0].weight);
    assign hit       = zero_reg ? (CNT_W'(cells[0].idx) == target_reg)
                                : (sum_add > thresh_reg);

    always_comb begin
        state_next    = state_reg;
        tau_next      = tau_reg;
        id_next       = id_reg;
        value_next    = value_reg;
        rnd_next      = rnd_reg;
        last_next     = last_reg;
        w_next        = w_reg;
        count_next    = count_reg;
        zero_next     = zero_reg;
        err_next      = err_reg;
        total_next    = total_reg;
        thresh_next   = thresh_reg;
        target_next   = target_reg;
        sum_next      = sum_reg;
        remain_next   = remain_reg;
        chosen_next   = chosen_reg;
        m_valid_next  = m_valid_reg;
        m_chosen_next = m_chosen_reg;
        m_status_next = m_status_reg;
        unit_start    = 1'b0;
        chain_ctrl    = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            tau_next = cfg_temperature;
        end

        case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    id_next    = s_action_id;
                    value_next = s_action_value;
                    rnd_next   = s_random_fraction;
                    last_next  = s_last_item;
                    if (count_reg >= CNT_W'(MAX_ACTIONS)) begin
                        // dropped request; a dropped last still selects
                        err_next = ST_OVERFLOW;
                        if (s_last_item) begin
                            state_next = T_THR;
                        end
                    end else if (s_action_value == 32'sd0) begin
                        zero_next  = 1'b1;
                        w_next     = ONE_Q16;
                        state_next = T_INS;
                    end else if (!s_action_value[31]) begin
                        if (err_reg < ST_POSITIVE) begin
                            err_next = ST_POSITIVE;
                        end
                        w_next     = '0;
                        state_next = T_INS;
                    end else begin
                        state_next = T_CALC;
                    end
                end
            end
            T_CALC: begin
                unit_start = !unit_busy && !unit_done;
                if (unit_done) begin
                    w_next     = unit_weight;
                    state_next = T_INS;
                end
            end
            T_INS: begin
                chain_ctrl.insert = 1'b1;
                count_next        = count_reg + CNT_W'(1);
                total_next        = total_reg + SUM_W'(w_reg);
                state_next        = last_reg ? T_THR : T_IDLE;
            end
            T_THR: begin
                thresh_next = thr_prod[SUM_W+15:16];
                target_next = tgt_prod[CNT_W+15:16];
                sum_next    = '0;
                remain_next = count_reg;
                state_next  = T_WALK;
            end
            T_WALK: begin
                if (hit || remain_reg == CNT_W'(1)) begin
                    chosen_next      = cells[0].id;
                    chain_ctrl.clear = 1'b1;
                    state_next       = T_OUT;
                end else begin
                    chain_ctrl.shift = 1'b1;
                    sum_next         = sum_add;
                    remain_next      = remain_reg - CNT_W'(1);
                end
            end
            T_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_chosen_next = chosen_reg;
                    m_status_next = (err_reg != ST_SOFTMAX) ? err_reg
                                  : (zero_reg ? ST_UNIFORM : ST_SOFTMAX);
                    count_next    = '0;
                    zero_next     = 1'b0;
                    err_next      = ST_SOFTMAX;
                    total_next    = '0;
                    state_next    = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            tau_reg     <= 16'd256;
            count_reg   <= '0;
            zero_reg    <= 1'b0;
            err_reg     <= ST_SOFTMAX;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tau_reg     <= tau_next;
            count_reg   <= count_next;
            zero_reg    <= zero_next;
            err_reg     <= err_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
        id_reg       <= id_next;
        value_reg    <= value_next;
        rnd_reg      <= rnd_next;
        last_reg     <= last_next;
        w_reg        <= w_next;
        thresh_reg   <= thresh_next;
        target_reg   <= target_next;
        sum_reg      <= sum_next;
        remain_reg   <= remain_next;
        chosen_reg   <= chosen_next;
        m_chosen_reg <= m_chosen_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_chosen_action = m_chosen_reg;
    assign m_status        = m_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ACTIONS))
        else $error("entry count beyond chain length");

    a_unit_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_busy |-> (state_reg == T_CALC))
        else $error("weight unit busy outside calc state");

    a_walk_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_WALK) |-> cells[0].valid)
        else $error("walk reached an empty chain head");
`endif

endmodule

`default_nettype wire

>>> verif/softmax_action_selector_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// softmax_action_selector_unit_tb: self-checking bench of the action selector
// Streams candidate sets through the request channel under several
// temperatures. A bit-accurate selection model or a directed row gives each
// expected id and status, compared in order. Both channels idle at random.
// ---------------------------------------------------------------------------

module softmax_action_selector_unit_tb;

    import sas_pkg::*;

    localparam int          SET_MAX    = MAX_ACTIONS;
    localparam logic [63:0] LOG10E     = 64'd28462;
    localparam logic [31:0] UNIT_WT    = 32'h0001_0000;
    localparam int          IDLE_WAIT  = 200;  // well past one weight + walk pass

    typedef struct {
        logic [15:0] chosen;
        logic [1:0]  status;
    } choice_t;

    typedef struct {
        logic [15:0]        id;
        logic signed [31:0] value;
        logic [15:0]        rnd;
        logic               last;
        bit                 typed;   // expected result written in the row
        logic [15:0]        exp_id;
        logic [1:0]         exp_st;
    } row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_temperature;
    logic               s_valid;
    logic               s_ready;
    logic [15:0]        s_action_id;
    logic signed [31:0] s_action_value;
    logic [15:0]        s_random_fraction;
    logic               s_last_item;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_chosen_action;
    logic [1:0]         m_status;

    softmax_action_selector_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_temperature   (cfg_temperature),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action_id       (s_action_id),
        .s_action_value    (s_action_value),
        .s_random_fraction (s_random_fraction),
        .s_last_item       (s_last_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_chosen_action   (m_chosen_action),
        .m_status          (m_status)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // -----------------------------------------------------------------------
    // Selection model state: the set loaded so far and the temperature
    // -----------------------------------------------------------------------
    logic [15:0] cand_ids [SET_MAX];
    logic [31:0] cand_wts [SET_MAX];
    int          cand_cnt;
    bit          saw_zero;
    logic [1:0]  err_code;
    logic [63:0] wt_sum;
    logic [15:0] tau_reg;

    choice_t     pending_choices [$];
    int          errors;
    int          reqs_sent;
    int          results_seen;
    int          status_hits [4];

    function automatic logic [63:0] isqrt_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b   = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 of magnitude, Q6.16, by mantissa squaring
    function automatic logic [31:0] log2_mag(input logic [63:0] m);
        int          p;
        logic [63:0] y;
        logic [15:0] frac;
        p    = 0;
        frac = '0;
        while (p < 63 && (m >> (p + 1)) != 0) p++;
        y = m << (31 - p);
        for (int i = 0; i < 16; i++) begin
            y    = (y * y) >> 31;
            frac = frac << 1;
            if (y >= (64'd1 << 32)) begin
                y       = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return {p[15:0], frac};
    endfunction

    // 2^e for e in signed Q.16, saturated Q16.16
    function automatic logic [31:0] exp2_sat(input longint e);
        logic [63:0] ep;
        logic [63:0] prod;
        logic [63:0] root;
        int          n;
        logic [15:0] f;
        prod = 64'd1 << 30;
        root = 64'd1 << 31;
        if (e >= 64'sd16 * 65536) return 32'hFFFF_FFFF;
        if (e < -64'sd16 * 65536) return 32'h0;
        ep = e + 64'sd16 * 65536;
        n  = int'(ep >> 16);
        f  = ep[15:0];
        for (int k = 1; k <= 16; k++) begin
            root = isqrt_floor(root << 30);
            if (f[16-k]) prod = (prod * root) >> 30;
        end
        return 32'((prod << n) >> 30);
    endfunction

    function automatic logic [31:0] boltzmann_weight(input logic [31:0] raw);
        logic [63:0] m;
        longint      lx;
        logic [63:0] mag;
        logic [63:0] tau;
        m   = {32'd0, 32'd0 - raw};
        lx  = longint'(log2_mag(m)) - 64'sd16 * 65536;
        mag = (lx < 0 ? -lx : lx) * LOG10E;
        tau = (tau_reg == 0) ? 64'd1 : {48'd0, tau_reg};
        mag = mag / (tau * 256);
        return exp2_sat(lx > 0 ? -longint'(mag) : longint'(mag));
    endfunction

    // Load one candidate; on the last one, run the roulette wheel.
    function automatic bit select_action(input logic [15:0] id,
                                         input logic [31:0] raw,
                                         input logic [15:0] rnd,
                                         input logic last,
                                         output choice_t res);
        logic [15:0] ord_ids [SET_MAX];
        logic [31:0] ord_wts [SET_MAX];
        logic [31:0] w;
        logic [63:0] total;
        logic [63:0] thresh;
        logic [63:0] run;
        int          j;
        bit          hit;
        if (cand_cnt >= SET_MAX) begin
            err_code = ST_OVERFLOW;
        end else begin
            if (raw == 0) begin
                saw_zero = 1'b1;
                w        = UNIT_WT;
            end else if (!raw[31]) begin
                if (err_code < ST_POSITIVE) err_code = ST_POSITIVE;
                w = '0;
            end else begin
                w = boltzmann_weight(raw);
            end
            cand_ids[cand_cnt] = id;
            cand_wts[cand_cnt] = w;
            wt_sum             = wt_sum + w;
            cand_cnt++;
        end
        if (!last) return 1'b0;

        // stable descending insertion: ties stay in load order
        for (int i = 0; i < cand_cnt; i++) begin
            w = saw_zero ? UNIT_WT : cand_wts[i];
            j = i;
            while (j > 0 && ord_wts[j-1] < w) begin
                ord_wts[j] = ord_wts[j-1];
                ord_ids[j] = ord_ids[j-1];
                j--;
            end
            ord_wts[j] = w;
            ord_ids[j] = cand_ids[i];
        end
        total      = saw_zero ? 64'(cand_cnt) * UNIT_WT : wt_sum;
        thresh     = ({48'd0, rnd} * total) >> 16;
        res.chosen = (cand_cnt > 0) ? ord_ids[cand_cnt-1] : 16'd0;
        run        = '0;
        hit        = 1'b0;
        for (int i = 0; i < cand_cnt; i++) begin
            run = run + ord_wts[i];
            if (!hit && run > thresh) begin
                res.chosen = ord_ids[i];
                hit        = 1'b1;
            end
        end
        res.status = (err_code != ST_SOFTMAX) ? err_code
                   : (saw_zero ? ST_UNIFORM : ST_SOFTMAX);
        cand_cnt   = 0;
        saw_zero   = 1'b0;
        err_code   = '0;
        wt_sum     = '0;
        return 1'b1;
    endfunction

    // -----------------------------------------------------------------------
    // Result side: random back-pressure, in-order compare
    // -----------------------------------------------------------------------
    int stall_left;

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            // mostly short stalls, now and then a long one
            case ($urandom_range(0, 99)) inside
                [0:14]:  stall_left <= $urandom_range(1, 3);
                [15:16]: stall_left <= $urandom_range(20, 120);
                default: stall_left <= 0;
            endcase
        end
    end

    always @(posedge aclk) begin
        choice_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_choices.size() == 0) begin
                errors++;
                $display("%0t: unexpected result id=%h status=%0d", $time,
                         m_chosen_action, m_status);
            end else begin
                exp_c = pending_choices.pop_front();
                status_hits[m_status]++;
                if (m_chosen_action !== exp_c.chosen) begin
                    errors++;
                    $display("%0t: chosen_action expected %h actual %h", $time,
                             exp_c.chosen, m_chosen_action);
                end
                if (m_status !== exp_c.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_c.status, m_status);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------

    // Drive one request from the falling edge; the model runs on acceptance.
    task automatic send_request(input row_t r);
        int      gap;
        choice_t res;
        case ($urandom_range(0, 99)) inside
            [0:59]:  gap = 0;
            [60:94]: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(20, 100);
        endcase
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_action_id       <= r.id;
        s_action_value    <= r.value;
        s_random_fraction <= r.rnd;
        s_last_item       <= r.last;
        do @(posedge aclk); while (!s_ready);
        reqs_sent++;
        if (select_action(r.id, r.value, r.rnd, r.last, res)) begin
            if (r.typed) begin
                res.chosen = r.exp_id;
                res.status = r.exp_st;
            end
            pending_choices = {pending_choices, res};
        end
        @(negedge aclk);
    endtask

    // Sender holds off until every result is back and the block is quiet.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_choices.size() != 0) @(negedge aclk);
        repeat (IDLE_WAIT) @(negedge aclk);
    endtask

    task automatic write_tau(input logic [15:0] t);
        cfg_valid       <= 1'b1;
        cfg_temperature <= t;
        do @(posedge aclk); while (!cfg_ready);
        tau_reg = t;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic row_t mk_row(input logic [15:0] id, input logic [31:0] v,
                                    input logic [15:0] rnd, input logic last);
        row_t r;
        r.id     = id;
        r.value  = v;
        r.rnd    = rnd;
        r.last   = last;
        r.typed  = 1'b0;
        r.exp_id = '0;
        r.exp_st = '0;
        return r;
    endfunction

    function automatic row_t mk_typed(input logic [15:0] id, input logic [31:0] v,
                                      input logic [15:0] rnd, input logic last,
                                      input logic [15:0] eid, input logic [1:0] est);
        row_t r;
        r        = mk_row(id, v, rnd, last);
        r.typed  = 1'b1;
        r.exp_id = eid;
        r.exp_st = est;
        return r;
    endfunction

    // Random candidate value: mostly negative over all magnitudes
    function automatic logic [31:0] rand_value();
        logic [31:0] mag;
        case ($urandom_range(0, 99)) inside
            [0:2]:   return 32'h0;
            [3:5]:   return 32'($urandom_range(1, 32'h7FFF_FFFF));
            [6:7]:   return 32'hFFFF_FFFF;
            8:       return 32'h8000_0000;
            [9:10]:  return 32'hFFFF_0000;
            default: begin
                mag = (($urandom >> $urandom_range(0, 31)) & 32'h7FFF_FFFF) + 1;
                return 32'd0 - mag;
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_fraction();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    row_t        dir_rows [$];
    logic [15:0] phase_tau [10];
    int          set_len;
    int          phase_items;
    int          sets_done;

    initial begin
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_temperature   = '0;
        s_valid           = 1'b0;
        s_action_id       = '0;
        s_action_value    = '0;
        s_random_fraction = '0;
        s_last_item       = 1'b0;
        m_ready           = 1'b0;
        stall_left        = 0;
        cand_cnt          = 0;
        saw_zero          = 1'b0;
        err_code          = '0;
        wt_sum            = '0;
        tau_reg           = 16'd256;
        errors            = 0;
        reqs_sent         = 0;
        results_seen      = 0;
        sets_done         = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part, at the reset temperature
        // lone zero-valued candidate: itself, uniform
        dir_rows = {dir_rows, mk_typed(16'h1234, 32'h0, 16'hFFFF, 1'b1,
                                       16'h1234, ST_UNIFORM)};
        // lone largest positive value: itself, positive flag
        dir_rows = {dir_rows, mk_typed(16'hFFFF, 32'h7FFF_FFFF, 16'h0, 1'b1,
                                       16'hFFFF, ST_POSITIVE)};
        // smallest and largest magnitudes
        dir_rows = {dir_rows, mk_row(16'h0005, 32'hFFFF_FFFF, 16'h0, 1'b0)};
        dir_rows = {dir_rows, mk_row(16'h0006, 32'h8000_0000, 16'hFFFF, 1'b1)};
        // zero value forces equal weights; rnd 0 picks the first loaded
        dir_rows = {dir_rows, mk_row(16'h0011, 32'hFFFF_0000, 16'h1234, 1'b0)};
        dir_rows = {dir_rows, mk_row(16'h0022, 32'h0, 16'h1234, 1'b0)};
        dir_rows = {dir_rows, mk_typed(16'h0033, 32'hFFF0_0000, 16'h0, 1'b1,
                                       16'h0011, ST_UNIFORM)};
        // overlong set: seventeen candidates, the last one dropped
        for (int i = 0; i < SET_MAX + 1; i++) begin
            dir_rows = {dir_rows, mk_row(16'(16'hA000 + i), 32'hFFFF_0000 - (i << 12),
                                         16'hFFFF, i == SET_MAX)};
        end
        foreach (dir_rows[i]) send_request(dir_rows[i]);
        drain_results();

        // Random part: one temperature per phase, extremes included
        phase_tau = '{16'd1, 16'd65535, 16'd0, 16'd256, 16'd16, 16'd4096,
                      16'h0, 16'h0, 16'h0, 16'h0};
        for (int p = 6; p < 10; p++) phase_tau[p] = 16'($urandom_range(1, 65535));
        foreach (phase_tau[p]) begin
            write_tau(phase_tau[p]);
            phase_items = 0;
            while (phase_items < 80) begin
                case ($urandom_range(0, 19)) inside
                    [0:12]:  set_len = $urandom_range(1, 5);
                    [13:17]: set_len = $urandom_range(6, SET_MAX);
                    default: set_len = $urandom_range(SET_MAX + 1, SET_MAX + 4);
                endcase
                for (int k = 0; k < set_len; k++) begin
                    send_request(mk_row(16'($urandom), rand_value(), rand_fraction(),
                                        k == set_len - 1));
                end
                phase_items += set_len;
                sets_done++;
            end
            drain_results();
        end

        $display("Covered %0d requests in %0d random sets over 10 temperatures,",
                 reqs_sent, sets_done);
        $display("results by status softmax/uniform/positive/overflow: %0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
        if (errors == 0 && pending_choices.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #20ms;
        $display("%0t: timeout with %0d results outstanding", $time,
                 pending_choices.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/sas_pkg.sv
rtl/sas_weight_unit.sv
rtl/sas_cell.sv
rtl/softmax_action_selector_unit.sv
verif/softmax_action_selector_unit_tb.sv
